FILE: design/pst_pkg.sv
// Shared types and constants for the process slot table.
// Used by pst_scan_ctrl and process_slot_table_core.
package pst_pkg;

	localparam int TABLE_SLOTS_DEF = 64;

	localparam int MODE_W    = 3;
	localparam int OWNER_W   = 16;
	localparam int PID_W     = 31;
	localparam int RANK_W    = 6;
	localparam int STATUS_W  = 2;
	localparam int CNT_OUT_W = 7;
	localparam int IN_W      = MODE_W + OWNER_W + PID_W + RANK_W;
	localparam int OUT_W     = STATUS_W + PID_W + OWNER_W + CNT_OUT_W;

	localparam logic [MODE_W-1:0] MODE_SPAWN = 3'd0;
	localparam logic [MODE_W-1:0] MODE_EXIT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_KILL  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COUNT = 3'd3;
	localparam logic [MODE_W-1:0] MODE_NTH   = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_PROTECTED = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd3;

	localparam logic [PID_W-1:0] PID_RESET_NEXT = 31'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic ready;
		logic scan_valid;
		logic done;
	} ctrl_t;

endpackage

FILE: design/pst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/pst_scan_ctrl.sv
// Sequencer for the slot scan: state register, read address counter and
// the stage that lines up a slot index with its read data. Uses pst_pkg.
module pst_scan_ctrl #(
	parameter int TABLE_SLOTS = pst_pkg::TABLE_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           scan_req,
	input  logic                           stop,
	input  logic                           out_free,
	output pst_pkg::ctrl_t                 ctl,
	output logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
	output logic [$clog2(TABLE_SLOTS)-1:0] idx_s1
);
	import pst_pkg::*;

	localparam int IW = $clog2(TABLE_SLOTS);

	state_t        state_q;
	state_t        state_d;
	logic [IW:0]   issue_q;
	logic          valid_s1;
	logic          issue_more;
	logic          finish;

	assign issue_more = (state_q == ST_SCAN) && (issue_q < (IW+1)'(TABLE_SLOTS));
	assign finish     = valid_s1 && (stop || (idx_s1 == IW'(TABLE_SLOTS - 1)));
	assign rd_addr    = issue_q[IW-1:0];

	always_comb begin
		state_d        = state_q;
		ctl.ready      = 1'b0;
		ctl.scan_valid = valid_s1;
		ctl.done       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.ready = 1'b1;
				if (start) begin
					state_d = scan_req ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (finish) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				ctl.done = 1'b1;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issue_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				issue_q  <= '0;
				valid_s1 <= 1'b0;
			end else begin
				valid_s1 <= issue_more && !finish;
				if (issue_more) begin
					issue_q <= issue_q + (IW+1)'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[IW-1:0];
	end

endmodule

FILE: design/process_slot_table_core.sv
// Top level of the process slot table: used bits, counters, slot memory
// and result register. Uses pst_pkg, pst_ram and pst_scan_ctrl.
//
// Spawn, exit, kill and nth-entry beats walk the table one slot per cycle
// through the single read port of the slot memory; spawn, kill and nth stop
// at the first hit. Count beats and kill of id 0 or 1 do not walk the table.
// s_tready is high only while no beat is in work; a finished result waits
// in the output register while the next beat is taken. Slot memory needs
// no clearing pass.
module process_slot_table_core #(
	parameter int TABLE_SLOTS = pst_pkg::TABLE_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [pst_pkg::IN_W-1:0]  s_tdata,  // mode, owner, target_pid, rank
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [pst_pkg::OUT_W-1:0] m_tdata   // status, pid_out, owner_out, used_count
);
	import pst_pkg::*;

	localparam int IW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int SW = (CW > RANK_W) ? CW : RANK_W;
	localparam int RW = PID_W + OWNER_W;

	ctrl_t               ctl;
	logic                start;
	logic                scan_req;
	logic                stop;
	logic                out_free;
	logic [IW-1:0]       rd_addr;
	logic [IW-1:0]       idx_s1;
	logic [RW-1:0]       rdata;
	logic                ram_we;

	logic [MODE_W-1:0]   in_mode;
	logic [OWNER_W-1:0]  in_owner;
	logic [PID_W-1:0]    in_target;
	logic [RANK_W-1:0]   in_rank;

	logic [MODE_W-1:0]   mode_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [PID_W-1:0]    target_q;
	logic [RANK_W-1:0]   rank_q;

	logic [TABLE_SLOTS-1:0] used_q, used_d;
	logic [1:0]          wr01_q, wr01_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [PID_W-1:0]    next_id_q, next_id_d;
	logic [SW-1:0]       seen_q, seen_d;

	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic [PID_W-1:0]    res_pid_q, res_pid_d;
	logic [OWNER_W-1:0]  res_owner_q, res_owner_d;

	logic                slot_used;
	logic [PID_W-1:0]    slot_pid;
	logic [OWNER_W-1:0]  slot_owner;
	logic                slot_init;
	logic                slot_match;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	assign in_mode   = s_tdata[2:0];
	assign in_owner  = s_tdata[18:3];
	assign in_target = s_tdata[49:19];
	assign in_rank   = s_tdata[55:50];

	assign s_tready = ctl.ready;
	assign start    = s_tvalid && s_tready;
	assign scan_req = (in_mode == MODE_SPAWN) || (in_mode == MODE_EXIT) ||
	                  (in_mode == MODE_NTH) ||
	                  ((in_mode == MODE_KILL) && (in_target > PID_W'(1)));
	assign out_free = !m_tvalid || m_tready;

	pst_scan_ctrl #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.scan_req (scan_req),
		.stop     (stop),
		.out_free (out_free),
		.ctl      (ctl),
		.rd_addr  (rd_addr),
		.idx_s1   (idx_s1)
	);

	pst_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata ({owner_q, next_id_q}),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign slot_used  = used_q[idx_s1];
	assign slot_init  = (idx_s1 <= IW'(1)) && !wr01_q[idx_s1[0]];
	assign slot_pid   = slot_init ? PID_W'(idx_s1) : rdata[PID_W-1:0];
	assign slot_owner = slot_init ? '0 : rdata[RW-1:PID_W];
	assign slot_match = slot_used && (slot_pid == target_q);

	always_comb begin
		used_d       = used_q;
		wr01_d       = wr01_q;
		cnt_d        = cnt_q;
		next_id_d    = next_id_q;
		seen_d       = seen_q;
		res_status_d = res_status_q;
		res_pid_d    = res_pid_q;
		res_owner_d  = res_owner_q;
		stop         = 1'b0;
		ram_we       = 1'b0;
		if (start) begin
			seen_d      = '0;
			res_pid_d   = '0;
			res_owner_d = '0;
			priority if (in_mode == MODE_SPAWN) begin
				res_status_d = STAT_FULL;
			end else if (in_mode == MODE_KILL) begin
				res_status_d = (in_target > PID_W'(1)) ? STAT_NOT_FOUND : STAT_PROTECTED;
			end else if (in_mode == MODE_NTH) begin
				res_status_d = STAT_NOT_FOUND;
			end else begin
				res_status_d = STAT_OK;
			end
		end else if (ctl.scan_valid) begin
			priority if (mode_q == MODE_SPAWN) begin
				if (!slot_used) begin
					used_d[idx_s1] = 1'b1;
					ram_we         = 1'b1;
					if (idx_s1 <= IW'(1)) begin
						wr01_d[idx_s1[0]] = 1'b1;
					end
					cnt_d        = cnt_q + CW'(1);
					res_pid_d    = next_id_q;
					next_id_d    = next_id_q + PID_W'(1);
					res_status_d = STAT_OK;
					stop         = 1'b1;
				end
			end else if (mode_q == MODE_EXIT) begin
				if (slot_match) begin
					used_d[idx_s1] = 1'b0;
					cnt_d          = cnt_q - CW'(1);
				end
			end else if (mode_q == MODE_KILL) begin
				if (slot_match) begin
					used_d[idx_s1] = 1'b0;
					cnt_d          = cnt_q - CW'(1);
					res_status_d   = STAT_OK;
					stop           = 1'b1;
				end
			end else begin
				if (slot_used) begin
					if (seen_q == SW'(rank_q)) begin
						res_pid_d    = slot_pid;
						res_owner_d  = slot_owner;
						res_status_d = STAT_OK;
						stop         = 1'b1;
					end else begin
						seen_d = seen_q + SW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= TABLE_SLOTS'(3);
			wr01_q    <= '0;
			cnt_q     <= CW'(2);
			next_id_q <= PID_RESET_NEXT;
			m_tvalid  <= 1'b0;
		end else begin
			used_q    <= used_d;
			wr01_q    <= wr01_d;
			cnt_q     <= cnt_d;
			next_id_q <= next_id_d;
			if (ctl.done && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign cnt_ext = (CW+CNT_OUT_W)'(cnt_q);

	always_ff @(posedge clk) begin
		seen_q       <= seen_d;
		res_status_q <= res_status_d;
		res_pid_q    <= res_pid_d;
		res_owner_q  <= res_owner_d;
		if (start) begin
			mode_q   <= in_mode;
			owner_q  <= in_owner;
			target_q <= in_target;
			rank_q   <= in_rank;
		end
		if (ctl.done && out_free) begin
			m_tdata <= {cnt_ext[CNT_OUT_W-1:0], res_owner_q, res_pid_q, res_status_q};
		end
	end

	a_cnt_tracks_used: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) == $countones(used_q))
		else $error("used count out of step with used bits");

	a_spawn_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !used_q[idx_s1])
		else $error("spawn wrote a used slot");

	a_no_scan_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !ctl.scan_valid)
		else $error("scan stage active while taking beats");

	a_spawn_advances_id: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> next_id_q == $past(next_id_q) + PID_W'(1))
		else $error("id counter did not advance on spawn");

endmodule
